[rtl/modbus_rtu_register_master_defines.svh]
// Assertion macros shared by the Modbus RTU register master RTL.
`ifndef MODBUS_RTU_REGISTER_MASTER_DEFINES_SVH
`define MODBUS_RTU_REGISTER_MASTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mrm_pkg.sv]
// Types, constants and the CRC-16 helper for the Modbus RTU register master.
package mrm_pkg;

    // Command queue depth between the front and back ends
    localparam int MRM_QUEUE_DEPTH = 4;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_READ    = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_RX_BYTE = 2'd2,
        MODE_TICK    = 2'd3
    } t_mode;

    // Modbus function codes and exception flag
    localparam logic [7:0] FUNC_READ     = 8'h03;
    localparam logic [7:0] FUNC_WRITE    = 8'h06;
    localparam logic [7:0] FUNC_EXC_MASK = 8'h80;
    localparam logic [15:0] READ_QUANTITY = 16'd1;

    // CRC-16 (reflected)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Response lengths in bytes
    localparam logic [3:0] RD_FRAME_LEN = 4'd9;
    localparam logic [3:0] WR_FRAME_LEN = 4'd8;
    localparam logic [3:0] CRC_MIN_LEN  = 4'd5;
    localparam logic [3:0] WR_ECHO_LEN  = 4'd6;
    localparam logic [3:0] RD_FULL_LEN  = 4'd7;

    // Completion status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_TIMEOUT    = 3'd1;
    localparam logic [2:0] STAT_SHORT      = 3'd2;
    localparam logic [2:0] STAT_WRONG_ADDR = 3'd3;
    localparam logic [2:0] STAT_EXCEPTION  = 3'd4;
    localparam logic [2:0] STAT_ECHO       = 3'd5;

    // Result kinds
    localparam logic KIND_TX_BYTE = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'd1;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    // Classified command held in the queue
    typedef struct packed {
        t_mode       mode;
        logic [15:0] word_a;   // register address, or received byte in the low bits
        logic [15:0] word_b;   // write value, or read quantity
    } t_cmd;

    // Back-end status seen by the top level
    typedef struct packed {
        logic busy;
        logic in_tx;
        logic emit;
        logic emit_last;
    } t_back_stat;

    // One byte folded into a reflected CRC-16
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/mrm_channels.sv]
// Handshake channel interfaces: request items, results and configuration writes.
interface mrm_req_if;
    import mrm_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] reg_address;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
    modport source (output valid, mode, reg_address, write_value, rx_byte, input ready);
    modport sink   (input valid, mode, reg_address, write_value, rx_byte, output ready);
endinterface

interface mrm_rsp_if;
    import mrm_pkg::*;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [2:0]  status;
    logic [15:0] read_value;
    modport source (output valid, result_kind, tx_byte, last_byte, status, read_value,
                    input ready);
    modport sink   (input valid, result_kind, tx_byte, last_byte, status, read_value,
                    output ready);
endinterface

interface mrm_cfg_if;
    import mrm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mrm_fifo.sv]
// Small register queue of classified commands between front and back ends.
module mrm_fifo #(
    parameter int DEPTH = mrm_pkg::MRM_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrm_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output mrm_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import mrm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/mrm_front.sv]
// Front end: accepts input items and packs them into queue commands.
module mrm_front (
    mrm_req_if.sink       i_req,
    input  logic          i_full,
    output logic          o_push,
    output mrm_pkg::t_cmd o_cmd
);
    import mrm_pkg::*;

    t_mode mode;

    assign mode        = t_mode'(i_req.mode);
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // classify: received bytes carry only their byte, reads carry quantity one
    always_comb begin
        o_cmd.mode   = mode;
        o_cmd.word_a = i_req.reg_address;
        o_cmd.word_b = READ_QUANTITY;
        case (mode)
            MODE_WRITE: begin
                o_cmd.word_b = i_req.write_value;
            end
            MODE_RX_BYTE: begin
                o_cmd.word_a = {8'h00, i_req.rx_byte};
            end
            MODE_TICK: begin
                o_cmd.word_a = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/mrm_back.sv]
// Back end: transaction engine, frame builder, response checker and result register.
module mrm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_slave_address,
    input  logic [15:0]        i_timeout_ticks,
    input  logic               i_head_valid,
    input  mrm_pkg::t_cmd      i_head,
    output logic               o_pop,
    mrm_rsp_if.source          o_rsp,
    output mrm_pkg::t_back_stat o_stat
);
    import mrm_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_TX  = 2'b10
    } t_state;

    // control
    t_state      r_state, n_state;
    logic        r_busy, n_busy;
    logic [2:0]  r_tx_idx, n_tx_idx;
    logic        r_out_valid;

    // transaction context
    logic        r_is_write, n_is_write;
    logic [15:0] r_held_reg, n_held_reg;
    logic [15:0] r_held_val, n_held_val;
    logic [15:0] r_tx_crc, n_tx_crc;
    logic [3:0]  r_byte_count, n_byte_count;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [7:0]  r_tail0, n_tail0;
    logic [7:0]  r_tail1, n_tail1;
    logic [7:0]  r_resp_addr, n_resp_addr;
    logic [7:0]  r_resp_func, n_resp_func;
    logic [15:0] r_resp_data, n_resp_data;
    logic        r_echo_diff, n_echo_diff;
    logic [15:0] r_tick_count, n_tick_count;

    // result register payload
    logic        r_out_kind;
    logic [7:0]  r_out_tx;
    logic        r_out_last;
    logic [2:0]  r_out_status;
    logic [15:0] r_out_value;

    // emitted result this cycle
    logic        slot_free;
    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_tx;
    logic        emit_last;
    logic [2:0]  emit_status;
    logic [15:0] emit_value;

    // frame byte and receive-side evaluation
    logic [7:0]  tx_byte;
    logic [7:0]  rx_b;
    logic [3:0]  rx_limit;
    logic        rx_in_frame;
    logic [15:0] rx_crc_next;
    logic [7:0]  rx_expect;
    logic        rx_echo_next;
    logic [3:0]  rx_count_next;
    logic [7:0]  rx_addr_next;
    logic [7:0]  rx_func_next;
    logic [15:0] rx_data_next;
    logic        rx_done;
    logic [2:0]  rx_status;
    logic [15:0] rx_value;
    logic [15:0] tick_next;
    logic        tick_timeout;

    assign slot_free = !r_out_valid || o_rsp.ready;

    // request frame byte at the current transmit position
    always_comb begin
        case (r_tx_idx)
            3'd0:    tx_byte = i_slave_address;
            3'd1:    tx_byte = r_is_write ? FUNC_WRITE : FUNC_READ;
            3'd2:    tx_byte = r_held_reg[15:8];
            3'd3:    tx_byte = r_held_reg[7:0];
            3'd4:    tx_byte = r_held_val[15:8];
            3'd5:    tx_byte = r_held_val[7:0];
            3'd6:    tx_byte = r_tx_crc[7:0];
            default: tx_byte = r_tx_crc[15:8];
        endcase
    end

    // expected echo byte for the received position
    always_comb begin
        case (r_byte_count)
            4'd1:    rx_expect = r_is_write ? FUNC_WRITE : FUNC_READ;
            4'd2:    rx_expect = r_held_reg[15:8];
            4'd3:    rx_expect = r_held_reg[7:0];
            4'd4:    rx_expect = r_held_val[15:8];
            4'd5:    rx_expect = r_held_val[7:0];
            default: rx_expect = 8'h00;
        endcase
    end

    // received byte: CRC lags two bytes behind, tail holds the candidate checksum
    always_comb begin
        rx_b          = i_head.word_a[7:0];
        rx_limit      = r_is_write ? WR_FRAME_LEN : RD_FRAME_LEN;
        rx_in_frame   = (r_byte_count < rx_limit);
        rx_crc_next   = (r_byte_count >= 4'd2) ? crc_fold(r_rx_crc, r_tail0) : r_rx_crc;
        rx_echo_next  = r_echo_diff ||
                        ((r_byte_count >= 4'd1) && (r_byte_count <= 4'd5) &&
                         (rx_b != rx_expect));
        rx_count_next = r_byte_count + 4'd1;
        rx_addr_next  = (r_byte_count == 4'd0) ? rx_b : r_resp_addr;
        rx_func_next  = (r_byte_count == 4'd1) ? rx_b : r_resp_func;
        case (r_byte_count)
            4'd3:    rx_data_next = {rx_b, r_resp_data[7:0]};
            4'd4:    rx_data_next = {r_resp_data[15:8], rx_b};
            default: rx_data_next = r_resp_data;
        endcase
        rx_done = (rx_count_next >= CRC_MIN_LEN) && (rx_crc_next == {rx_b, r_tail1});

        rx_value = 16'h0000;
        if (r_is_write) begin
            if ((rx_count_next < WR_ECHO_LEN) || rx_echo_next ||
                (rx_addr_next != i_slave_address)) begin
                rx_status = STAT_ECHO;
            end else begin
                rx_status = STAT_OK;
            end
        end else if (rx_count_next < RD_FULL_LEN) begin
            rx_status = STAT_SHORT;
        end else if (rx_addr_next != i_slave_address) begin
            rx_status = STAT_WRONG_ADDR;
        end else if ((rx_func_next & FUNC_EXC_MASK) != 8'h00) begin
            rx_status = STAT_EXCEPTION;
        end else begin
            rx_status = STAT_OK;
            rx_value  = rx_data_next;
        end
    end

    // saturating tick counter
    assign tick_next    = (r_tick_count != 16'hFFFF) ? r_tick_count + 16'd1 : r_tick_count;
    assign tick_timeout = (tick_next >= i_timeout_ticks);

    // engine
    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_tx_idx     = r_tx_idx;
        n_is_write   = r_is_write;
        n_held_reg   = r_held_reg;
        n_held_val   = r_held_val;
        n_tx_crc     = r_tx_crc;
        n_byte_count = r_byte_count;
        n_rx_crc     = r_rx_crc;
        n_tail0      = r_tail0;
        n_tail1      = r_tail1;
        n_resp_addr  = r_resp_addr;
        n_resp_func  = r_resp_func;
        n_resp_data  = r_resp_data;
        n_echo_diff  = r_echo_diff;
        n_tick_count = r_tick_count;
        o_pop        = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_TX_BYTE;
        emit_tx      = 8'h00;
        emit_last    = 1'b0;
        emit_status  = STAT_OK;
        emit_value   = 16'h0000;

        case (r_state)
            // one request byte per free result slot, CRC folded as bytes go out
            ST_TX: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_tx   = tx_byte;
                    emit_last = (r_tx_idx == 3'd7);
                    if (r_tx_idx < 3'd6) begin
                        n_tx_crc = crc_fold(r_tx_crc, tx_byte);
                    end
                    n_tx_idx = r_tx_idx + 3'd1;
                    if (r_tx_idx == 3'd7) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_head_valid) begin
                    case (i_head.mode)
                        MODE_READ, MODE_WRITE: begin
                            o_pop = 1'b1;
                            if (!r_busy) begin
                                n_busy       = 1'b1;
                                n_state      = ST_TX;
                                n_tx_idx     = 3'd0;
                                n_is_write   = (i_head.mode == MODE_WRITE);
                                n_held_reg   = i_head.word_a;
                                n_held_val   = i_head.word_b;
                                n_tx_crc     = CRC_INIT;
                                n_byte_count = 4'd0;
                                n_rx_crc     = CRC_INIT;
                                n_tail0      = 8'h00;
                                n_tail1      = 8'h00;
                                n_resp_addr  = 8'h00;
                                n_resp_func  = 8'h00;
                                n_resp_data  = 16'h0000;
                                n_echo_diff  = 1'b0;
                                n_tick_count = 16'h0000;
                            end
                        end
                        MODE_TICK: begin
                            if (!r_busy) begin
                                o_pop = 1'b1;
                            end else if (!tick_timeout || slot_free) begin
                                o_pop        = 1'b1;
                                n_tick_count = tick_next;
                                if (tick_timeout) begin
                                    n_busy      = 1'b0;
                                    emit        = 1'b1;
                                    emit_kind   = KIND_DONE;
                                    emit_status = STAT_TIMEOUT;
                                end
                            end
                        end
                        default: begin
                            // received byte
                            if (!r_busy || !rx_in_frame) begin
                                o_pop = 1'b1;
                            end else if (!rx_done || slot_free) begin
                                o_pop        = 1'b1;
                                n_rx_crc     = rx_crc_next;
                                n_tail0      = r_tail1;
                                n_tail1      = rx_b;
                                n_resp_addr  = rx_addr_next;
                                n_resp_func  = rx_func_next;
                                n_resp_data  = rx_data_next;
                                n_echo_diff  = rx_echo_next;
                                n_byte_count = rx_count_next;
                                if (rx_done) begin
                                    n_busy      = 1'b0;
                                    emit        = 1'b1;
                                    emit_kind   = KIND_DONE;
                                    emit_status = rx_status;
                                    emit_value  = rx_value;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_busy      <= 1'b0;
            r_tx_idx    <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_tx_idx <= n_tx_idx;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction context and result payload
    always_ff @(posedge i_clk) begin
        r_is_write   <= n_is_write;
        r_held_reg   <= n_held_reg;
        r_held_val   <= n_held_val;
        r_tx_crc     <= n_tx_crc;
        r_byte_count <= n_byte_count;
        r_rx_crc     <= n_rx_crc;
        r_tail0      <= n_tail0;
        r_tail1      <= n_tail1;
        r_resp_addr  <= n_resp_addr;
        r_resp_func  <= n_resp_func;
        r_resp_data  <= n_resp_data;
        r_echo_diff  <= n_echo_diff;
        r_tick_count <= n_tick_count;
        if (emit) begin
            r_out_kind   <= emit_kind;
            r_out_tx     <= emit_tx;
            r_out_last   <= emit_last;
            r_out_status <= emit_status;
            r_out_value  <= emit_value;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.tx_byte     = r_out_tx;
    assign o_rsp.last_byte   = r_out_last;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.read_value  = r_out_value;

    assign o_stat.busy      = r_busy;
    assign o_stat.in_tx     = (r_state == ST_TX);
    assign o_stat.emit      = emit;
    assign o_stat.emit_last = emit_last;

endmodule

[rtl/modbus_rtu_register_master.sv]
// Modbus RTU single-register master: builds read (function 3) and write (function 6)
// request frames with CRC-16 and checks the slave's response. Items are accepted one
// per cycle while the command queue (QUEUE_DEPTH deep) is not full. The back end takes a
// received byte, tick or dropped item as it reaches the queue head (a closing byte or
// timeout tick waits for the single result register to be free); a request it latches,
// then sends its eight frame bytes, one per free result slot. A completion is loaded into
// the result register in the cycle its closing byte or timeout tick is taken and shows on
// the result port from the next cycle. Configuration writes are taken every cycle.
`include "modbus_rtu_register_master_defines.svh"

module modbus_rtu_register_master #(
    parameter int QUEUE_DEPTH = mrm_pkg::MRM_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrm_req_if.sink   i_req,
    mrm_rsp_if.source o_rsp,
    mrm_cfg_if.sink   i_cfg
);
    import mrm_pkg::*;

    logic [7:0]  r_slave_addr;
    logic [15:0] r_timeout_ticks;
    logic        push;
    logic        full;
    logic        head_valid;
    logic        pop;
    t_cmd        push_cmd;
    t_cmd        head_cmd;
    t_back_stat  stat;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr    <= SLAVE_ADDRESS_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SLAVE_ADDRESS: r_slave_addr    <= i_cfg.data[7:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    mrm_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    mrm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_cmd),
        .i_pop   (pop)
    );

    mrm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_address (r_slave_addr),
        .i_timeout_ticks (r_timeout_ticks),
        .i_head_valid    (head_valid),
        .i_head          (head_cmd),
        .o_pop           (pop),
        .o_rsp           (o_rsp),
        .o_stat          (stat)
    );

    // checks
    `MRM_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
    `MRM_ASSERT_NOW(a_tx_busy, stat.in_tx, stat.busy, "frame transmit outside a transaction")
    `MRM_ASSERT_NEXT(a_last_ends_tx, stat.emit && stat.emit_last, !stat.in_tx, "tx past last")
    `MRM_ASSERT_NOW(a_pop_has_head, pop, head_valid, "pop from empty queue")

endmodule

[tb/tb.sv]
// Self-checking testbench for the Modbus RTU register master: random frames, replies and stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrm_pkg::*;

    localparam int DRAIN_CYCLES       = 60;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int RX_HOLD_CYCLES     = 400;
    localparam int EXCHANGES_PER_PHASE = 4;
    localparam int MAX_REPORTS        = 30;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] reg_address;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
    } t_master_input;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [2:0]  status;
        logic [15:0] value;
    } t_master_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrm_req_if req_if ();
    mrm_rsp_if rsp_if ();
    mrm_cfg_if cfg_if ();

    modbus_rtu_register_master u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be offered, and frame bytes / completions owed by the master
    t_master_input  master_inputs_q [$];
    t_master_result tx_and_done_q [$];
    logic [7:0]     reply_body [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    bit rx_hold_req  = 1'b0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    // Register copies
    logic [7:0]  cfg_slave   = SLAVE_ADDRESS_RST;
    logic [15:0] cfg_timeout = TIMEOUT_TICKS_RST;

    // Master state copy
    logic        mst_busy     = 1'b0;
    logic        mst_is_write = 1'b0;
    logic [15:0] mst_reg      = '0;
    logic [15:0] mst_val      = '0;
    logic [3:0]  mst_count    = '0;
    logic [15:0] mst_crc      = CRC_INIT;
    logic [7:0]  mst_tail [2] = '{8'h00, 8'h00};
    logic [7:0]  mst_rsp_addr = '0;
    logic [7:0]  mst_rsp_func = '0;
    logic [15:0] mst_rsp_data = '0;
    logic        mst_echo_bad = 1'b0;
    logic [15:0] mst_ticks    = '0;

    // Reflected CRC-16, one byte
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) begin
            if (c[0]) c = {1'b0, c[15:1]} ^ CRC_POLY;
            else c = {1'b0, c[15:1]};
        end
        return c;
    endfunction

    // Printable form of one result
    function automatic string fmt_result(input t_master_result r);
        return $sformatf("kind=%0d tx=%02h last=%0d status=%0d value=%04h",
                         r.kind, r.tx_byte, r.last, r.status, r.value);
    endfunction

    task automatic owe_result(input logic kind, input logic [7:0] tx, input logic last,
                              input logic [2:0] st, input logic [15:0] val);
        t_master_result r;
        r = '{kind, tx, last, st, val};
        tx_and_done_q.push_back(r);
    endtask

    // Advance the master copy by one accepted item
    task automatic master_take_item(input t_master_input it);
        logic [7:0]  frame [8];
        logic [15:0] crc;
        logic [3:0]  limit;
        logic [3:0]  n;
        logic [7:0]  b;
        logic [2:0]  st;
        logic [15:0] val;
        b = it.rx_byte;
        case (it.mode)
            MODE_READ, MODE_WRITE: begin
                // a request while waiting on a reply is ignored
                if (!mst_busy) begin
                    mst_is_write = (it.mode == MODE_WRITE);
                    mst_reg = it.reg_address;
                    mst_val = mst_is_write ? it.write_value : READ_QUANTITY;
                    frame[0] = cfg_slave;
                    frame[1] = mst_is_write ? FUNC_WRITE : FUNC_READ;
                    frame[2] = mst_reg[15:8];
                    frame[3] = mst_reg[7:0];
                    frame[4] = mst_val[15:8];
                    frame[5] = mst_val[7:0];
                    crc = CRC_INIT;
                    for (int i = 0; i < 6; i++) crc = crc16_fold(crc, frame[i]);
                    frame[6] = crc[7:0];
                    frame[7] = crc[15:8];
                    for (int i = 0; i < 8; i++) begin
                        owe_result(KIND_TX_BYTE, frame[i], i == 7, STAT_OK, 16'h0000);
                    end
                    mst_busy = 1'b1;
                    mst_count = '0;
                    mst_crc = CRC_INIT;
                    mst_tail[0] = '0;
                    mst_tail[1] = '0;
                    mst_rsp_addr = '0;
                    mst_rsp_func = '0;
                    mst_rsp_data = '0;
                    mst_echo_bad = 1'b0;
                    mst_ticks = '0;
                end
            end
            MODE_TICK: begin
                if (mst_busy) begin
                    if (mst_ticks != 16'hFFFF) mst_ticks = mst_ticks + 16'd1;
                    if (mst_ticks >= cfg_timeout) begin
                        mst_busy = 1'b0;
                        owe_result(KIND_DONE, 8'h00, 1'b0, STAT_TIMEOUT, 16'h0000);
                    end
                end
            end
            default: begin
                limit = mst_is_write ? WR_FRAME_LEN : RD_FRAME_LEN;
                n = mst_count;
                // bytes while idle or past the frame size are dropped
                if (mst_busy && n < limit) begin
                    if (n >= 2) mst_crc = crc16_fold(mst_crc, mst_tail[0]);
                    mst_tail[0] = mst_tail[1];
                    mst_tail[1] = b;
                    case (n)
                        4'd0: mst_rsp_addr = b;
                        4'd1: begin
                            mst_rsp_func = b;
                            if (b != (mst_is_write ? FUNC_WRITE : FUNC_READ)) mst_echo_bad = 1'b1;
                        end
                        4'd2: if (b != mst_reg[15:8]) mst_echo_bad = 1'b1;
                        4'd3: begin
                            mst_rsp_data[15:8] = b;
                            if (b != mst_reg[7:0]) mst_echo_bad = 1'b1;
                        end
                        4'd4: begin
                            mst_rsp_data[7:0] = b;
                            if (b != mst_val[15:8]) mst_echo_bad = 1'b1;
                        end
                        4'd5: if (b != mst_val[7:0]) mst_echo_bad = 1'b1;
                        default: ;
                    endcase
                    n = n + 4'd1;
                    mst_count = n;
                    // trailing two bytes hold the CRC of everything before them
                    if (n >= CRC_MIN_LEN && mst_crc == {mst_tail[1], mst_tail[0]}) begin
                        val = 16'h0000;
                        if (mst_is_write) begin
                            if (n < WR_ECHO_LEN || mst_echo_bad || mst_rsp_addr != cfg_slave)
                                st = STAT_ECHO;
                            else
                                st = STAT_OK;
                        end else if (n < RD_FULL_LEN) begin
                            st = STAT_SHORT;
                        end else if (mst_rsp_addr != cfg_slave) begin
                            st = STAT_WRONG_ADDR;
                        end else if ((mst_rsp_func & FUNC_EXC_MASK) != 8'h00) begin
                            st = STAT_EXCEPTION;
                        end else begin
                            st = STAT_OK;
                            val = mst_rsp_data;
                        end
                        mst_busy = 1'b0;
                        owe_result(KIND_DONE, 8'h00, 1'b0, st, val);
                    end
                end
            end
        endcase
    endtask

    // Request driver: take the next item once the current one is gone
    always @(posedge i_clk) begin
        t_master_input nxt;
        t_master_input took;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                took = '{t_mode'(req_if.mode), req_if.reg_address, req_if.write_value,
                         req_if.rx_byte};
                master_take_item(took);
            end
            if (!req_if.valid || req_if.ready) begin
                if (master_inputs_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt = master_inputs_q.pop_front();
                    req_if.mode        <= nxt.mode;
                    req_if.reg_address <= nxt.reg_address;
                    req_if.write_value <= nxt.write_value;
                    req_if.rx_byte     <= nxt.rx_byte;
                    req_if.valid       <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_master_result got;
        t_master_result want;
        got = '{rsp_if.result_kind, rsp_if.tx_byte, rsp_if.last_byte, rsp_if.status,
                rsp_if.read_value};
        rsp_if.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (tx_and_done_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result expected none, actual %s",
                             $time, fmt_result(got));
            end else begin
                want = tx_and_done_q.pop_front();
                if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                    got.last !== want.last || got.status !== want.status ||
                    got.value !== want.value) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch expected %s, actual %s",
                                 $time, fmt_result(want), fmt_result(got));
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_item(input t_mode m, input logic [15:0] ra, input logic [15:0] wv,
                              input logic [7:0] b);
        t_master_input it;
        it = '{m, ra, wv, b};
        master_inputs_q.push_back(it);
    endtask

    task automatic queue_request(input logic wr, input logic [15:0] ra, input logic [15:0] wv);
        if (wr) queue_item(MODE_WRITE, ra, wv, 8'($urandom));
        else queue_item(MODE_READ, ra, wv, 8'($urandom));
    endtask

    task automatic queue_ticks(input int count);
        repeat (count) queue_item(MODE_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic queue_noise_bytes(input int count);
        repeat (count) queue_item(MODE_RX_BYTE, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Send reply_body followed by its CRC, low byte first; a bad CRC gets one bit flipped
    task automatic queue_reply(input bit good_crc);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (reply_body[i]) begin
            crc = crc16_fold(crc, reply_body[i]);
            queue_item(MODE_RX_BYTE, 16'($urandom), 16'($urandom), reply_body[i]);
        end
        if (!good_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
        queue_item(MODE_RX_BYTE, 16'($urandom), 16'($urandom), crc[7:0]);
        queue_item(MODE_RX_BYTE, 16'($urandom), 16'($urandom), crc[15:8]);
    endtask

    // Enough ticks to run out the timeout
    task automatic queue_timeout_ticks();
        int count;
        count = (cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout);
        queue_ticks(count + $urandom_range(0, 2));
    endtask

    // One request and a reply shaped at random
    task automatic run_exchange();
        logic        wr;
        logic [15:0] ra;
        logic [15:0] wv;
        logic [15:0] data;
        logic [7:0]  addr;
        int          pick;
        int          cut;
        int          pos;
        wr   = 1'($urandom_range(0, 1));
        ra   = 16'($urandom);
        wv   = 16'($urandom);
        data = 16'($urandom);
        addr = cfg_slave;
        queue_request(wr, ra, wv);
        // second request while busy is ignored
        if ($urandom_range(0, 5) == 0) queue_request(!wr, 16'($urandom), 16'($urandom));
        if (wr) reply_body = {addr, FUNC_WRITE, ra[15:8], ra[7:0], wv[15:8], wv[7:0]};
        else reply_body = {addr, FUNC_READ, 8'd2, data[15:8], data[7:0]};
        pick = $urandom_range(0, 11);
        if (pick <= 4 && cfg_timeout > 16'd3 && $urandom_range(0, 2) == 0)
            queue_ticks($urandom_range(1, 2));
        case (pick)
            5: reply_body[0] = addr ^ 8'($urandom_range(1, 255));
            6: begin
                if ($urandom_range(0, 1) != 0)
                    reply_body = {addr, reply_body[1] | FUNC_EXC_MASK, 8'($urandom)};
                else
                    reply_body[1] = reply_body[1] | FUNC_EXC_MASK;
            end
            7: begin
                cut = $urandom_range(3, 4);
                while (reply_body.size() > cut) void'(reply_body.pop_back());
            end
            8: begin
                pos = $urandom_range(1, reply_body.size() - 1);
                reply_body[pos] = reply_body[pos] ^ 8'(1 << $urandom_range(0, 7));
            end
            11: begin
                queue_noise_bytes($urandom_range(1, 6));
                if ($urandom_range(0, 1) != 0) queue_ticks(1);
            end
            default: ;
        endcase
        if (pick == 10 && cfg_timeout <= 16'd40) begin
            // silent slave
            queue_timeout_ticks();
        end else begin
            queue_reply(pick != 9);
            if (pick == 9) begin
                // corrupt frame, then noise bytes, then the timeout if cfg_timeout is at most 40
                queue_noise_bytes($urandom_range(0, 4));
                if (cfg_timeout <= 16'd40) queue_timeout_ticks();
            end
        end
        // stray item after completion, dropped while idle
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) != 0) queue_noise_bytes(1);
            else queue_ticks(1);
        end
    endtask

    task automatic wait_all_done();
        while (master_inputs_q.size() != 0 || req_if.valid || tx_and_done_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        wait_quiet();
        @(posedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_SLAVE_ADDRESS) cfg_slave = data[7:0];
        else cfg_timeout = data;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] slave, input logic [15:0] timeout,
                             input int idle, input int stall, input bit hold);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(CFG_SLAVE_ADDRESS, {junk, slave});
        write_reg(CFG_TIMEOUT_TICKS, timeout);
        tx_idle_pct  = idle;
        rx_stall_pct = stall;
        if (hold) begin
            rx_hold_req = 1'b1;
            while (rx_hold_left == 0) @(negedge i_clk);
            rx_hold_req = 1'b0;
        end
        for (int k = 0; k < EXCHANGES_PER_PHASE; k++) begin
            // sender pauses midway until the master has answered everything
            if (k == EXCHANGES_PER_PHASE / 2) wait_all_done();
            run_exchange();
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_TICK;
        req_if.reg_address = '0;
        req_if.write_value = '0;
        req_if.rx_byte     = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_SLAVE_ADDRESS;
        cfg_if.data        = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle drops, extreme fields, request while busy,
        // five-byte write answer, read exception
        queue_item(MODE_RX_BYTE, 16'hFFFF, 16'hFFFF, 8'hFF);
        queue_item(MODE_TICK, 16'h0000, 16'h0000, 8'h00);
        queue_request(1'b0, 16'hFFFF, 16'h0000);
        queue_request(1'b1, 16'h0000, 16'hFFFF);
        reply_body = {cfg_slave, FUNC_READ, 8'd2, 8'hFF, 8'hFF};
        queue_reply(1'b1);
        queue_request(1'b1, 16'h0000, 16'hFFFF);
        reply_body = {cfg_slave, FUNC_WRITE, 8'h00};
        queue_reply(1'b1);
        queue_request(1'b0, 16'h8000, 16'h0001);
        reply_body = {cfg_slave, FUNC_READ | FUNC_EXC_MASK, 8'h02, 8'h00, 8'h00};
        queue_reply(1'b1);

        // random phases over register extremes and idling patterns
        run_phase(8'hFF, 16'd0, 0, 0, 1'b0);
        run_phase(8'h00, 16'd1, 77, 0, 1'b0);
        run_phase(8'($urandom), 16'hFFFF, 0, 77, 1'b0);
        run_phase(8'hA5, 16'd4, 19, 19, 1'b0);
        run_phase(8'($urandom), 16'd2, 0, 0, 1'b1);

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
